### hdl/hqsp_pkg.sv
// Package: transfer types, character constants and hex helpers for the pattern decoder.
package hqsp_pkg;

  // One pattern character as it arrives.
  typedef struct packed {
    logic [15:0] char_code;
    logic        last_char;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_pattern;
    logic       pattern_failed;
  } out_item_t;

  // Number of results one character can cause (0, 1 or 2).
  typedef logic [1:0] res_count_t;

  localparam logic [15:0] DoubleQuote = 16'h0022;
  localparam logic [15:0] SingleQuote = 16'h0027;
  localparam logic [15:0] ByteLimit   = 16'h0080;
  localparam logic [3:0]  TenNibble   = 4'd10;

  // True for 0-9, a-f and A-F.
  function automatic logic is_hex(input logic [15:0] c);
    is_hex = (c >= 16'h0030 && c <= 16'h0039) ||
             (c >= 16'h0061 && c <= 16'h0066) ||
             (c >= 16'h0041 && c <= 16'h0046);
  endfunction

  // Nibble value of a hex digit.
  function automatic logic [3:0] hex_val(input logic [15:0] c);
    logic [3:0] v;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      v = c[3:0];
    end else begin
      // a-f and A-F share the low three bits 1..6
      v = TenNibble + {1'b0, c[2:0]} - 4'd1;
    end
    hex_val = v;
  endfunction

endpackage

### hdl/hqsp_decode.sv
// Character decoder: quote and nibble state, and the up to two results per character.
module hqsp_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  hqsp_pkg::in_item_t  item_i,
  output hqsp_pkg::out_item_t res0_o,
  output hqsp_pkg::out_item_t res1_o,
  output hqsp_pkg::res_count_t num_o
);

  logic       wide_q, wide_d;
  logic       byteq_q, byteq_d;
  logic       nw_q, nw_d;
  logic [3:0] hn_q, hn_d;
  logic       err_q, err_d;

  // Decode of the incoming character against the current state
  always_comb begin
    logic [15:0] c;
    logic        consumed;
    logic [7:0]  pend;
    logic        pend_v;
    c        = item_i.char_code;
    consumed = 1'b0;
    pend     = 8'd0;
    pend_v   = 1'b0;
    res0_o   = '0;
    res1_o   = '0;
    num_o    = 2'd0;
    wide_d   = wide_q;
    byteq_d  = byteq_q;
    nw_d     = nw_q;
    hn_d     = hn_q;
    err_d    = err_q;

    // flush or pair a waiting nibble
    if (nw_q) begin
      nw_d = 1'b0;
      hn_d = 4'd0;
      if (hqsp_pkg::is_hex(c)) begin
        res0_o.data_byte = {hn_q, hqsp_pkg::hex_val(c)};
        consumed         = 1'b1;
      end else begin
        res0_o.data_byte = {4'd0, hn_q};
      end
      res0_o.byte_valid = 1'b1;
      num_o             = 2'd1;
    end

    if (!consumed) begin
      if (c == hqsp_pkg::DoubleQuote && !byteq_q) begin
        wide_d = ~wide_q;
      end else if (c == hqsp_pkg::SingleQuote && !wide_q) begin
        byteq_d = ~byteq_q;
      end else if (wide_q) begin
        // no nibble can wait inside quotes, so both slots are free
        res0_o.data_byte  = c[7:0];
        res0_o.byte_valid = 1'b1;
        res1_o.data_byte  = c[15:8];
        res1_o.byte_valid = 1'b1;
        num_o             = 2'd2;
      end else if (byteq_q) begin
        if (c < hqsp_pkg::ByteLimit) begin
          pend   = c[7:0];
          pend_v = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end else if (hqsp_pkg::is_hex(c)) begin
        if (item_i.last_char) begin
          pend   = {4'd0, hqsp_pkg::hex_val(c)};
          pend_v = 1'b1;
        end else begin
          nw_d = 1'b1;
          hn_d = hqsp_pkg::hex_val(c);
        end
      end
    end

    // single byte from this character goes into the next free slot
    if (pend_v) begin
      if (num_o == 2'd0) begin
        res0_o.data_byte  = pend;
        res0_o.byte_valid = 1'b1;
        num_o             = 2'd1;
      end else begin
        res1_o.data_byte  = pend;
        res1_o.byte_valid = 1'b1;
        num_o             = 2'd2;
      end
    end

    // end of pattern: mark the final result, add a bare marker if none
    if (item_i.last_char) begin
      if (num_o == 2'd0) begin
        num_o = 2'd1;
      end
      if (num_o == 2'd1) begin
        res0_o.end_of_pattern = 1'b1;
        res0_o.pattern_failed = err_d;
      end else begin
        res1_o.end_of_pattern = 1'b1;
        res1_o.pattern_failed = err_d;
      end
      wide_d  = 1'b0;
      byteq_d = 1'b0;
      nw_d    = 1'b0;
      hn_d    = 4'd0;
      err_d   = 1'b0;
    end
  end

  // State registers, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q  <= 1'b0;
      byteq_q <= 1'b0;
      nw_q    <= 1'b0;
      hn_q    <= 4'd0;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      wide_q  <= wide_d;
      byteq_q <= byteq_d;
      nw_q    <= nw_d;
      hn_q    <= hn_d;
      err_q   <= err_d;
    end
  end

endmodule

### hdl/hex_quoted_search_pattern_decoder.sv
// Top level: search-pattern decoder with a four-entry result queue.
//
//  channel | direction | payload              | handshake
//  --------+-----------+----------------------+---------------------------
//  in      | input     | in_item_i  (17 bits) | in_valid_i / in_stall_o
//  out     | output    | out_item_o (11 bits) | out_valid_o / out_stall_i
//
// A character is decoded in the cycle it is transferred; its 0 to 2 results
// land in the queue and are offered on the output in order, one per cycle
// while out_stall_i is low. One character per cycle is taken while the queue
// has room for two results, so the rate is set by the single output port.
// Reset empties the queue and clears all quote and nibble state.
// in_stall_o rises only when more than two results are waiting; the head
// result holds while out_stall_i.
module hex_quoted_search_pattern_decoder #(
  parameter int unsigned QDepthLog2 = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hqsp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hqsp_pkg::out_item_t out_item_o
);

  localparam int unsigned QDepth = 1 << QDepthLog2;

  logic                in_xfer;
  logic                out_xfer;
  hqsp_pkg::out_item_t res0, res1;
  hqsp_pkg::res_count_t num;

  hqsp_pkg::out_item_t   queue_q [QDepth];
  logic [QDepthLog2-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QDepthLog2:0]   cnt_q, cnt_d;
  logic [QDepthLog2:0]   push;

  // Room for a worst-case character is two free entries
  assign in_stall_o  = (cnt_q > (QDepthLog2 + 1)'(QDepth - 2));
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign out_item_o  = queue_q[rd_q];

  hqsp_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_xfer),
    .item_i   (in_item_i),
    .res0_o   (res0),
    .res1_o   (res1),
    .num_o    (num)
  );

  // Queue pointer and fill arithmetic
  always_comb begin
    push  = in_xfer ? (QDepthLog2 + 1)'(num) : '0;
    wr_d  = wr_q + push[QDepthLog2-1:0];
    rd_d  = out_xfer ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + push - (QDepthLog2 + 1)'(out_xfer);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Result storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer && num != 2'd0) begin
      queue_q[wr_q] <= res0;
    end
    if (in_xfer && num == 2'd2) begin
      queue_q[wr_q + 1'b1] <= res1;
    end
  end

endmodule

### hdl/hqsp_checker.sv
// Checker: port-level assertions for the pattern decoder, bound to the top level.
module hqsp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input hqsp_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hqsp_pkg::out_item_t out_item_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn under stall");

  // A bare end marker carries no byte and closes the pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.byte_valid |->
      out_item_o.end_of_pattern && out_item_o.data_byte == 8'd0)
    else $error("bare marker not a clean end result");

  // Failure is only reported on the end result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pattern_failed |-> out_item_o.end_of_pattern)
    else $error("pattern_failed outside end result");

  // With nothing queued the input is never held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty queue");

  // A last character is always answered by a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.last_char |=> out_valid_o)
    else $error("no result after last character");

endmodule

bind hex_quoted_search_pattern_decoder hqsp_checker u_hqsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### dv/tb_top.sv
// Testbench for the hex and quoted-text search-pattern decoder: directed table, then random.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 1000;
  localparam int NumDirected = 25;
  localparam int RandomPerPhase = 400;

  // One row of the directed table; typed rows carry their results written out
  typedef struct packed {
    hqsp_pkg::in_item_t  stim;
    logic                typed;
    logic [1:0]          n_typed;
    hqsp_pkg::out_item_t r0;
    hqsp_pkg::out_item_t r1;
  } dir_row_t;

  localparam dir_row_t DirRows[NumDirected] = '{
    // lone digit on the last character
    '{'{16'h0030, 1'b1}, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1, 1'b0}, '0},
    // digit pair, upper then lower case, ends the pattern
    '{'{16'h0046, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{16'h0066, 1'b1}, 1'b1, 2'd1, '{8'hff, 1'b1, 1'b1, 1'b0}, '0},
    // held digit flushed by a non-hex character
    '{'{16'h0041, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{16'h0047, 1'b0}, 1'b1, 2'd1, '{8'h0a, 1'b1, 1'b0, 1'b0}, '0},
    // double quotes: two bytes per character, low byte first
    '{'{16'h0022, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{16'hffff, 1'b0}, 1'b1, 2'd2, '{8'hff, 1'b1, 1'b0, 1'b0},
      '{8'hff, 1'b1, 1'b0, 1'b0}},
    '{'{16'h0027, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{16'h0022, 1'b0}, 1'b1, 2'd0, '0, '0},
    // single quotes: a double quote passes, a high character is rejected
    '{'{16'h0027, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{16'h0022, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{16'h007f, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{16'h0080, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{16'h0000, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{16'h0027, 1'b0}, 1'b1, 2'd0, '0, '0},
    // held digit flushed on the last character, error still sticky
    '{'{16'h0039, 1'b0}, 1'b1, 2'd0, '0, '0},
    '{'{16'h0000, 1'b1}, 1'b1, 2'd1, '{8'h09, 1'b1, 1'b1, 1'b1}, '0},
    // bare end marker
    '{'{16'h0020, 1'b1}, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, 1'b0}, '0},
    '{'{16'h0061, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{16'h0042, 1'b1}, 1'b0, 2'd0, '0, '0},
    // rejected character, then a bare end marker that fails
    '{'{16'h0027, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{16'hffff, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{16'h0027, 1'b1}, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, 1'b1}, '0},
    // flush then quote toggle on the last character
    '{'{16'h0035, 1'b0}, 1'b0, 2'd0, '0, '0},
    '{'{16'h0022, 1'b1}, 1'b0, 2'd0, '0, '0}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  hqsp_pkg::in_item_t  in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  hqsp_pkg::out_item_t out_item_o;

  // Decoder state as predicted
  logic       wide_open;
  logic       narrow_open;
  logic       digit_held;
  logic [3:0] held_val;
  logic       sticky_err;

  hqsp_pkg::out_item_t pending_bytes[$];
  hqsp_pkg::out_item_t want;
  int                  mismatches;
  int                  quiet_cycles;
  int                  src_idle_pct;
  int                  snk_stall_pct;

  hex_quoted_search_pattern_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit is_digit(input logic [15:0] c);
    return (c inside {[16'h0030:16'h0039], [16'h0041:16'h0046], [16'h0061:16'h0066]});
  endfunction

  // Letters carry 1..6 in their low nibble, digits their value
  function automatic logic [3:0] nibble_of(input logic [15:0] c);
    return (c <= 16'h0039) ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic void clear_state();
    wide_open   = 1'b0;
    narrow_open = 1'b0;
    digit_held  = 1'b0;
    held_val    = '0;
    sticky_err  = 1'b0;
  endfunction

  // Append one expected result at the tail
  function automatic void queue_result(input hqsp_pkg::out_item_t r);
    pending_bytes.insert(pending_bytes.size(), r);
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    queue_result('{b, 1'b1, 1'b0, 1'b0});
  endfunction

  // Expected results of one character, appended to pending_bytes
  function automatic void decode_char(input hqsp_pkg::in_item_t it);
    logic [15:0]         c;
    bit                  paired;
    int                  n0;
    hqsp_pkg::out_item_t tail;
    c      = it.char_code;
    paired = 1'b0;
    n0     = pending_bytes.size();
    if (digit_held) begin
      digit_held = 1'b0;
      if (is_digit(c)) begin
        push_byte({held_val, nibble_of(c)});
        paired = 1'b1;
      end else begin
        push_byte({4'h0, held_val});
      end
      held_val = '0;
    end
    if (!paired) begin
      if (c == hqsp_pkg::DoubleQuote && !narrow_open) begin
        wide_open = ~wide_open;
      end else if (c == hqsp_pkg::SingleQuote && !wide_open) begin
        narrow_open = ~narrow_open;
      end else if (wide_open) begin
        push_byte(c[7:0]);
        push_byte(c[15:8]);
      end else if (narrow_open) begin
        if (c < hqsp_pkg::ByteLimit) push_byte(c[7:0]);
        else sticky_err = 1'b1;
      end else if (is_digit(c)) begin
        if (it.last_char) begin
          push_byte({4'h0, nibble_of(c)});
        end else begin
          digit_held = 1'b1;
          held_val   = nibble_of(c);
        end
      end
    end
    // last character: mark the final result, add a bare marker if none
    if (it.last_char) begin
      if (pending_bytes.size() == n0) queue_result('0);
      tail = pending_bytes.pop_back();
      tail.end_of_pattern = 1'b1;
      tail.pattern_failed = sticky_err;
      queue_result(tail);
      clear_state();
    end
  endfunction

  // Random character weighted towards digits, quotes and ASCII
  function automatic hqsp_pkg::in_item_t random_char();
    hqsp_pkg::in_item_t it;
    int                 pick;
    int                 idx;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      idx = $urandom_range(0, 21);
      if (idx < 10) it.char_code = 16'(16'h0030 + idx);
      else if (idx < 16) it.char_code = 16'(16'h0061 + idx - 10);
      else it.char_code = 16'(16'h0041 + idx - 16);
    end else if (pick < 45) begin
      it.char_code = hqsp_pkg::DoubleQuote;
    end else if (pick < 55) begin
      it.char_code = hqsp_pkg::SingleQuote;
    end else if (pick < 75) begin
      it.char_code = 16'($urandom_range(0, 127));
    end else if (pick < 90) begin
      it.char_code = 16'($urandom_range(0, 65535));
    end else begin
      it.char_code = 16'($urandom_range(128, 65535));
    end
    it.last_char = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  // One input transfer; entered and left at a falling edge
  task automatic send_char(input hqsp_pkg::in_item_t it, input bit typed,
                           input logic [1:0] n_typed,
                           input hqsp_pkg::out_item_t r0, input hqsp_pkg::out_item_t r1);
    int n0;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    n0 = pending_bytes.size();
    decode_char(it);
    if (typed) begin
      while (pending_bytes.size() > n0) void'(pending_bytes.pop_back());
      if (n_typed > 0) queue_result(r0);
      if (n_typed > 1) queue_result(r1);
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_bytes.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input int src, input int snk, input bit pause_midway);
    src_idle_pct  = src;
    snk_stall_pct = snk;
    for (int i = 0; i < RandomPerPhase; i++) begin
      if (pause_midway && i == RandomPerPhase / 2) drain();
      send_char(random_char(), 1'b0, 2'd0, '0, '0);
    end
  endtask

  // Receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < snk_stall_pct);
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result byte %02h valid %0d end %0d failed %0d", $time,
                 out_item_o.data_byte, out_item_o.byte_valid, out_item_o.end_of_pattern,
                 out_item_o.pattern_failed);
      end else begin
        want = pending_bytes.pop_front();
        if (out_item_o.data_byte !== want.data_byte ||
            out_item_o.byte_valid !== want.byte_valid ||
            out_item_o.end_of_pattern !== want.end_of_pattern ||
            out_item_o.pattern_failed !== want.pattern_failed) begin
          mismatches++;
          $display("%0t: expected %02h/%0d/%0d/%0d, got %02h/%0d/%0d/%0d",
                   $time, want.data_byte, want.byte_valid, want.end_of_pattern,
                   want.pattern_failed, out_item_o.data_byte, out_item_o.byte_valid,
                   out_item_o.end_of_pattern, out_item_o.pattern_failed);
        end
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    out_stall_i   = 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    clear_state();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table with light idling on both sides
    src_idle_pct  = 19;
    snk_stall_pct = 19;
    for (int i = 0; i < NumDirected; i++) begin
      send_char(DirRows[i].stim, DirRows[i].typed, DirRows[i].n_typed, DirRows[i].r0,
                DirRows[i].r1);
    end

    run_phase(0, 0, 1'b0);
    run_phase(73, 0, 1'b1);
    run_phase(0, 73, 1'b0);
    run_phase(19, 19, 1'b0);

    in_valid_i <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
